@@ hdl/mvm_pkg.sv @@
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants of the matrix-vector multiply block: register
// indexes, configuration struct, command codes and result field widths.
// ----------------------------------------------------------------------------
package mvm_pkg;

    // configuration register file
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIANGULAR_MODE = 2'd2;

    localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 7'd64;
    localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic [CFG_W-1:0] row_count;
        logic [CFG_W-1:0] column_count;
        logic             triangular_mode;
    } cfg_t;

    // request kinds on the input tuser
    localparam logic REQ_VECTOR = 1'b0;
    localparam logic REQ_MATRIX = 1'b1;

    // command codes passed from front to back
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_MAC  = 2'd1,
        OP_ERR  = 2'd2
    } op_t;

    typedef struct packed {
        op_t  op;
        logic acc_en;
        logic emit;
        logic last_row;
    } cmd_flags_t;

    localparam int CMD_FLAGS_W = $bits(cmd_flags_t);

    // result fields
    localparam int ACC_W       = 40;
    localparam int ROW_NUM_W   = 6;
    localparam int OUT_TDATA_W = ((ACC_W + ROW_NUM_W + 7) / 8) * 8;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

endpackage

@@ hdl/mvm_queue.sv @@
// ----------------------------------------------------------------------------
// mvm_queue
// Short register queue that decouples the request front end from the
// multiply-accumulate back end.
// ----------------------------------------------------------------------------
module mvm_queue #(
    parameter int WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [WIDTH-1:0]          push_data,
    input  logic                      pop,
    output logic [WIDTH-1:0]          pop_data,
    output logic                      not_empty,
    output logic                      full,
    output logic [mvm_pkg::QUEUE_AW:0] count
);
    import mvm_pkg::*;

    logic [WIDTH-1:0]    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign count     = count_reg;

endmodule

@@ hdl/mvm_front.sv @@
// ----------------------------------------------------------------------------
// mvm_front
// Accepts requests, tracks vector fill and matrix position, and turns each
// request into a load, multiply-accumulate or error command for the back end.
// ----------------------------------------------------------------------------
module mvm_front #(
    parameter int MAX_DIM      = 64,
    parameter int ELEMENT_BITS = 16,
    parameter int IN_W         = ((ELEMENT_BITS + 7) / 8) * 8,
    parameter int IDX_W        = $clog2(MAX_DIM)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mvm_pkg::cfg_t                       cfg,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_W-1:0]                     s_tdata,  // [element_value]
    input  logic                                s_tuser,  // [req_type]
    // command out
    input  logic                                q_full,
    output logic                                push,
    output mvm_pkg::cmd_flags_t                 cmd_flags,
    output logic [IDX_W-1:0]                    cmd_addr,
    output logic [mvm_pkg::ROW_NUM_W-1:0]       cmd_row,
    output logic signed [ELEMENT_BITS-1:0]      cmd_value
);
    import mvm_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    logic [DIM_W-1:0] fill_reg;
    logic [DIM_W-1:0] fill_next;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] row_next;
    logic [IDX_W-1:0] col_reg;
    logic [IDX_W-1:0] col_next;

    logic [CMP_W-1:0] rows_ext;
    logic [CMP_W-1:0] cols_ext;
    logic [CMP_W-1:0] rows_clamp;
    logic [CMP_W-1:0] cols_clamp;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic             fill_wrap;
    logic             mismatch;
    logic             last_col;
    logic             last_r;

    // sizes clamped to [1, MAX_DIM]
    always_comb
    begin
        rows_ext   = CMP_W'(cfg.row_count);
        cols_ext   = CMP_W'(cfg.column_count);
        rows_clamp = rows_ext;
        cols_clamp = cols_ext;
        if (rows_ext == '0)
        begin
            rows_clamp = CMP_W'(1);
        end
        else if (rows_ext > CMP_W'(MAX_DIM))
        begin
            rows_clamp = CMP_W'(MAX_DIM);
        end
        if (cols_ext == '0)
        begin
            cols_clamp = CMP_W'(1);
        end
        else if (cols_ext > CMP_W'(MAX_DIM))
        begin
            cols_clamp = CMP_W'(MAX_DIM);
        end
        rows = rows_clamp[DIM_W-1:0];
        cols = cols_clamp[DIM_W-1:0];
    end

    // request classification
    always_comb
    begin
        fill_wrap = (fill_reg >= cols);
        mismatch  = (fill_reg != cols) || (cfg.triangular_mode && (rows != cols));
        last_col  = ((DIM_W'(col_reg) + 1'b1) >= cols);
        last_r    = ((DIM_W'(row_reg) + 1'b1) >= rows);
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // command and next position
    always_comb
    begin
        fill_next          = fill_reg;
        row_next           = row_reg;
        col_next           = col_reg;
        cmd_flags.op       = OP_MAC;
        cmd_flags.acc_en   = 1'b0;
        cmd_flags.emit     = 1'b0;
        cmd_flags.last_row = 1'b0;
        cmd_addr           = col_reg;
        cmd_row            = ROW_NUM_W'(row_reg);
        cmd_value          = s_tdata[ELEMENT_BITS-1:0];
        if (s_tuser == REQ_VECTOR)
        begin
            // vector element: store and restart the matrix position
            cmd_flags.op = OP_LOAD;
            if (fill_wrap)
            begin
                cmd_addr  = '0;
                fill_next = DIM_W'(1);
            end
            else
            begin
                cmd_addr  = fill_reg[IDX_W-1:0];
                fill_next = fill_reg + 1'b1;
            end
            row_next = '0;
            col_next = '0;
        end
        else if (mismatch)
        begin
            cmd_flags.op = OP_ERR;
        end
        else
        begin
            cmd_flags.acc_en   = (DIM_W'(col_reg) < cols) &&
                                 (!cfg.triangular_mode || (col_reg < row_reg));
            cmd_flags.emit     = last_col;
            cmd_flags.last_row = last_r;
            if (last_col)
            begin
                col_next = '0;
                row_next = last_r ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else if (push)
        begin
            fill_reg <= fill_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

endmodule

@@ hdl/mvm_back.sv @@
// ----------------------------------------------------------------------------
// mvm_back
// Executes commands: vector store writes, store read, multiply, saturating
// accumulate and the result output register. Three stages, one stall enable.
// ----------------------------------------------------------------------------
module mvm_back #(
    parameter int MAX_DIM      = 64,
    parameter int ELEMENT_BITS = 16,
    parameter int IDX_W        = $clog2(MAX_DIM)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command in
    input  logic                                q_valid,
    output logic                                pop,
    input  mvm_pkg::cmd_flags_t                 cmd_flags,
    input  logic [IDX_W-1:0]                    cmd_addr,
    input  logic [mvm_pkg::ROW_NUM_W-1:0]       cmd_row,
    input  logic signed [ELEMENT_BITS-1:0]      cmd_value,
    // result out
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mvm_pkg::ACC_W-1:0]    out_result,
    output logic [mvm_pkg::ROW_NUM_W-1:0]       out_row,
    output logic                                out_last,
    output logic                                out_status
);
    import mvm_pkg::*;

    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

    logic signed [ELEMENT_BITS-1:0] vec_mem [MAX_DIM];

    logic                           advance;

    // stage 1: store access
    logic                           s1_valid_reg;
    cmd_flags_t                     s1_flags_reg;
    logic [ROW_NUM_W-1:0]           s1_row_reg;
    logic signed [ELEMENT_BITS-1:0] s1_value_reg;
    logic signed [ELEMENT_BITS-1:0] s1_vec_reg;

    // stage 2: product
    logic                           s2_valid_reg;
    cmd_flags_t                     s2_flags_reg;
    logic [ROW_NUM_W-1:0]           s2_row_reg;
    logic signed [PROD_W-1:0]       s2_prod_reg;

    // stage 3: accumulator and output
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [ACC_W-1:0]        out_result_reg;
    logic signed [ACC_W-1:0]        out_result_next;
    logic [ROW_NUM_W-1:0]           out_row_reg;
    logic [ROW_NUM_W-1:0]           out_row_next;
    logic                           out_last_reg;
    logic                           out_last_next;
    logic                           out_status_reg;
    logic                           out_status_next;

    logic signed [SUM_W-1:0]        acc_ext;
    logic signed [SUM_W-1:0]        prod_ext;
    logic signed [SUM_W-1:0]        sum_raw;
    logic signed [ACC_W-1:0]        sum_sat;

    // whole pipe moves unless a result is waiting on the receiver
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && q_valid;

    // vector store: one write and one registered read per cycle while the pipe advances
    always_ff @(posedge clk)
    begin
        if (pop && (cmd_flags.op == OP_LOAD))
        begin
            vec_mem[cmd_addr] <= cmd_value;
        end
        if (advance)
        begin
            s1_vec_reg   <= vec_mem[cmd_addr];
            s1_flags_reg <= cmd_flags;
            s1_row_reg   <= cmd_row;
            s1_value_reg <= cmd_value;
            s2_flags_reg <= s1_flags_reg;
            s2_row_reg   <= s1_row_reg;
            s2_prod_reg  <= s1_value_reg * s1_vec_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // saturating add of the product
    always_comb
    begin
        acc_ext  = {{(SUM_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
        prod_ext = {{(SUM_W-PROD_W){s2_prod_reg[PROD_W-1]}}, s2_prod_reg};
        sum_raw  = s2_flags_reg.acc_en ? acc_ext + prod_ext : acc_ext;
        if (sum_raw > SAT_MAX)
        begin
            sum_sat = SAT_MAX[ACC_W-1:0];
        end
        else if (sum_raw < SAT_MIN)
        begin
            sum_sat = SAT_MIN[ACC_W-1:0];
        end
        else
        begin
            sum_sat = sum_raw[ACC_W-1:0];
        end
    end

    // accumulator and result selection
    always_comb
    begin
        acc_next        = acc_reg;
        out_valid_next  = 1'b0;
        out_result_next = out_result_reg;
        out_row_next    = out_row_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        if (s2_valid_reg)
        begin
            case (s2_flags_reg.op)
                OP_LOAD:
                begin
                    acc_next = '0;
                end
                OP_MAC:
                begin
                    if (s2_flags_reg.emit)
                    begin
                        acc_next        = '0;
                        out_valid_next  = 1'b1;
                        out_result_next = sum_sat;
                        out_row_next    = s2_row_reg;
                        out_last_next   = s2_flags_reg.last_row;
                        out_status_next = STATUS_OK;
                    end
                    else
                    begin
                        acc_next = sum_sat;
                    end
                end
                OP_ERR:
                begin
                    out_valid_next  = 1'b1;
                    out_result_next = '0;
                    out_row_next    = s2_row_reg;
                    out_last_next   = 1'b0;
                    out_status_next = STATUS_ERROR;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= out_result_next;
            out_row_reg    <= out_row_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_row    = out_row_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

endmodule

@@ hdl/matrix_vector_multiply.sv @@
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Dense or strictly lower triangular product b = A*x in Q4.12 with a
// saturating Q16.24 accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   Write row_count, column_count and triangular_mode on the cfg port while
//   the block is idle. Then send the vector x as requests with tuser = 0,
//   one element each, followed by the matrix in row-major order with
//   tuser = 1. One result leaves on the m_ channel at the last column of
//   each row (tlast marks the final row), or right away for a matrix request
//   that arrives before the vector is complete or, in triangular mode, for a
//   non-square size (tuser = 1, result zero).
// Throughput: one request per cycle unless a result waits on the receiver.
//   The front end classifies requests combinationally; the back end does one
//   store access, one multiply and one accumulate per cycle in three stages.
// Path: queue, store read, product and output registers, in that order.
// Reset: position, fill count and accumulator clear at once; the vector
//   store is not cleared and needs a full vector load before use.
// Stall: a waiting result holds the back end; the 4-entry command queue
//   then fills and s_tready drops.
// ----------------------------------------------------------------------------
module matrix_vector_multiply #(
    parameter int MAX_DIM      = 64,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]             cfg_data,
    // request channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((ELEMENT_BITS+7)/8)*8-1:0]     s_tdata,  // [element_value]
    input  logic                                  s_tuser,  // [req_type]
    // result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mvm_pkg::OUT_TDATA_W-1:0]       m_tdata,  // [row_result, row_number]
    output logic                                  m_tlast,  // last_row
    output logic                                  m_tuser   // [status]
);
    import mvm_pkg::*;

    localparam int IN_W  = ((ELEMENT_BITS + 7) / 8) * 8;
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CMD_W = CMD_FLAGS_W + IDX_W + ROW_NUM_W + ELEMENT_BITS;

    cfg_t                           cfg_reg;
    cfg_t                           cfg_next;

    logic                           push;
    logic                           pop;
    logic                           q_full;
    logic                           q_valid;
    logic [QUEUE_AW:0]              q_count;
    logic [CMD_W-1:0]               q_in;
    logic [CMD_W-1:0]               q_out;

    cmd_flags_t                     f_flags;
    logic [IDX_W-1:0]               f_addr;
    logic [ROW_NUM_W-1:0]           f_row;
    logic signed [ELEMENT_BITS-1:0] f_value;

    cmd_flags_t                     b_flags;
    logic [IDX_W-1:0]               b_addr;
    logic [ROW_NUM_W-1:0]           b_row;
    logic signed [ELEMENT_BITS-1:0] b_value;

    logic signed [ACC_W-1:0]        res_value;
    logic [ROW_NUM_W-1:0]           res_row;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_COUNT:       cfg_next.row_count       = cfg_data;
                REG_COLUMN_COUNT:    cfg_next.column_count    = cfg_data;
                REG_TRIANGULAR_MODE: cfg_next.triangular_mode = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_count       <= ROW_COUNT_RESET;
            cfg_reg.column_count    <= COLUMN_COUNT_RESET;
            cfg_reg.triangular_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end
    mvm_front #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS),
        .IN_W         (IN_W),
        .IDX_W        (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .cmd_flags (f_flags),
        .cmd_addr  (f_addr),
        .cmd_row   (f_row),
        .cmd_value (f_value)
    );

    // command queue
    assign q_in = {f_flags, f_addr, f_row, f_value};

    mvm_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .pop       (pop),
        .pop_data  (q_out),
        .not_empty (q_valid),
        .full      (q_full),
        .count     (q_count)
    );

    assign {b_flags, b_addr, b_row, b_value} = q_out;

    // back end
    mvm_back #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS),
        .IDX_W        (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .pop        (pop),
        .cmd_flags  (b_flags),
        .cmd_addr   (b_addr),
        .cmd_row    (b_row),
        .cmd_value  (b_value),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res_value),
        .out_row    (res_row),
        .out_last   (m_tlast),
        .out_status (m_tuser)
    );

    assign m_tdata = {{(OUT_TDATA_W-ACC_W-ROW_NUM_W){1'b0}}, res_row, res_value};

    // checks
    a_err_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STATUS_ERROR)) |-> (!m_tlast && (res_value == '0)))
        else $error("error result carries data or last flag");

    a_ready_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (q_count == (QUEUE_AW+1)'(QUEUE_DEPTH)))
        else $error("request channel stalled with room in queue");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == (QUEUE_AW+1)'(QUEUE_DEPTH)) && !pop |=> !(push && !pop) || q_full)
        else $error("command queue overflow");

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (q_count != '0))
        else $error("command popped from empty queue");

endmodule

@@ dv/matrix_vector_multiply_checker.sv @@
// ----------------------------------------------------------------------------
// matrix_vector_multiply_checker
// Watches the configuration port and both stream channels of the
// matrix-vector multiply block. It keeps its own copy of the vector store,
// position and row accumulator, works out the row sum (or error) that each
// accepted request produces, and compares every accepted result field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_checker #(
    parameter int MAX_DIM      = 64,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration port
    input  logic                             cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]        cfg_data,
    // request channel
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [ELEMENT_BITS-1:0]          s_tdata,   // [element_value]
    input  logic                             s_tuser,   // [req_type]
    // result channel
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [mvm_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [row_result, row_number]
    input  logic                             m_tlast,   // last_row
    input  logic                             m_tuser,   // [status]
    // end of run: flag rows still outstanding
    input  logic                             end_check,
    output int                               mismatch_count,
    output int                               rows_pending,
    output int                               sums_seen,
    output int                               errors_seen,
    output int                               matrices_seen
);
    import mvm_pkg::*;

    localparam int     PAD_W        = OUT_TDATA_W - ACC_W - ROW_NUM_W;
    localparam longint SUM_MAX      = (longint'(1) << (ACC_W - 1)) - 1;
    localparam longint SUM_MIN      = -SUM_MAX - 1;
    localparam int     REPORT_LIMIT = 60;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc_value;
        logic [ROW_NUM_W-1:0]    row;
        logic                    last;
        logic                    status;
    } row_result_t;

    row_result_t expected_rows[$];

    // shadow of the register file
    logic [CFG_W-1:0] shadow_rows = ROW_COUNT_RESET;
    logic [CFG_W-1:0] shadow_cols = COLUMN_COUNT_RESET;
    logic             shadow_tri  = 1'b0;

    // shadow of the datapath state
    logic signed [ELEMENT_BITS-1:0] x_store [MAX_DIM];
    int                             fill_level = 0;
    logic signed [ACC_W-1:0]        row_sum    = '0;
    int                             row_pos    = 0;
    int                             col_pos    = 0;
    logic                           end_done   = 1'b0;

    initial
    begin
        mismatch_count = 0;
        rows_pending   = 0;
        sums_seen      = 0;
        errors_seen    = 0;
        matrices_seen  = 0;
    end

    // register value as the block uses it: 0 acts as 1, above MAX_DIM as MAX_DIM
    function automatic int used_dim(input logic [CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (int'(raw) > MAX_DIM)
            return MAX_DIM;
        return int'(raw);
    endfunction

    task automatic report_mismatch(input string what);
        // keep the log short when the block is badly broken
        if (mismatch_count < REPORT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // advance the shadow state by one request, queue any result it causes
    task automatic apply_request(input logic kind, input logic signed [ELEMENT_BITS-1:0] value);
        int          rows;
        int          cols;
        longint      total;
        row_result_t res;
        rows = used_dim(shadow_rows);
        cols = used_dim(shadow_cols);
        if (kind == REQ_VECTOR)
        begin
            // a full vector restarts at entry 0; any load rewinds the matrix
            if (fill_level >= cols || fill_level >= MAX_DIM)
                fill_level = 0;
            x_store[fill_level] = value;
            fill_level++;
            row_sum = '0;
            row_pos = 0;
            col_pos = 0;
        end
        else if (fill_level != cols || (shadow_tri && rows != cols))
        begin
            // vector incomplete or non-square triangular: dropped with error status
            res.acc_value = '0;
            res.row       = row_pos[ROW_NUM_W-1:0];
            res.last      = 1'b0;
            res.status    = STATUS_ERROR;
            expected_rows.push_back(res);
        end
        else
        begin
            if (col_pos < cols && col_pos < MAX_DIM && (!shadow_tri || col_pos < row_pos))
            begin
                total = longint'(row_sum) + longint'(value) * longint'(x_store[col_pos]);
                if (total > SUM_MAX)
                    total = SUM_MAX;
                if (total < SUM_MIN)
                    total = SUM_MIN;
                row_sum = total[ACC_W-1:0];
            end
            if (col_pos + 1 < cols)
                col_pos++;
            else
            begin
                res.acc_value = row_sum;
                res.row       = row_pos[ROW_NUM_W-1:0];
                res.last      = (row_pos + 1 >= rows);
                res.status    = STATUS_OK;
                expected_rows.push_back(res);
                row_sum = '0;
                col_pos = 0;
                row_pos = res.last ? 0 : row_pos + 1;
            end
        end
    endtask

    // compare one accepted result with the oldest prediction
    task automatic compare_result();
        row_result_t want;
        if (expected_rows.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing outstanding: data %h last %b status %b",
                                      m_tdata, m_tlast, m_tuser));
            return;
        end
        want = expected_rows.pop_front();
        if (m_tdata[ACC_W-1:0] !== want.acc_value)
            report_mismatch($sformatf("row %0d row_result %h, want %h",
                                      want.row, m_tdata[ACC_W-1:0], want.acc_value));
        if (m_tdata[ACC_W +: ROW_NUM_W] !== want.row)
            report_mismatch($sformatf("row_number %0d, want %0d",
                                      m_tdata[ACC_W +: ROW_NUM_W], want.row));
        if (m_tdata[OUT_TDATA_W-1 -: PAD_W] !== '0)
            report_mismatch($sformatf("row %0d tdata padding %b not zero",
                                      want.row, m_tdata[OUT_TDATA_W-1 -: PAD_W]));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("row %0d last_row %b, want %b", want.row, m_tlast, want.last));
        if (m_tuser !== want.status)
            report_mismatch($sformatf("row %0d status %b, want %b", want.row, m_tuser, want.status));
        if (want.status == STATUS_ERROR)
            errors_seen++;
        else
        begin
            sums_seen++;
            if (want.last)
                matrices_seen++;
        end
    endtask

    // one process per edge: config, request, then result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_rows = ROW_COUNT_RESET;
            shadow_cols = COLUMN_COUNT_RESET;
            shadow_tri  = 1'b0;
            fill_level  = 0;
            row_sum     = '0;
            row_pos     = 0;
            col_pos     = 0;
            expected_rows.delete();
            rows_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW_COUNT:       shadow_rows = cfg_data;
                    REG_COLUMN_COUNT:    shadow_cols = cfg_data;
                    REG_TRIANGULAR_MODE: shadow_tri  = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                compare_result();
            if (end_check && !end_done)
            begin
                end_done = 1'b1;
                if (expected_rows.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived", expected_rows.size()));
            end
            rows_pending <= expected_rows.size();
        end
    end

endmodule

@@ dv/matrix_vector_multiply_tb.sv @@
// ----------------------------------------------------------------------------
// matrix_vector_multiply_tb
// Drives the matrix-vector multiply block with a short directed sequence
// (edge values, early and non-square errors, vector reload, triangular rows)
// and then random shapes: vector loads, dense and triangular matrices,
// truncated matrices and stray requests, under random sender bursts and
// receiver stalls. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_tb;
    import mvm_pkg::*;

    localparam int MAX_DIM         = 64;
    localparam int ELEM_W          = 16;
    localparam int RANDOM_REQUESTS = 1400;
    localparam int PIPE_FLUSH      = 12;
    localparam int QUIET_LIMIT     = 400;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN,
        READY_BURSTY
    } ready_mode_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [ELEM_W-1:0]      s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   end_check = 1'b0;

    int          mismatch_count;
    int          rows_pending;
    int          sums_seen;
    int          errors_seen;
    int          matrices_seen;

    // stimulus bookkeeping
    ready_mode_t ready_mode    = READY_ALWAYS;
    logic        sender_steady = 1'b1;
    int          burst_left    = 0;
    int          requests_sent = 0;
    int          shapes_run    = 0;
    int          vector_fill   = 0;
    int          active_cols   = 64;
    int          ready_tick    = 0;
    int          hold_left     = 0;
    logic        hold_level    = 1'b0;
    int          quiet_cycles  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    matrix_vector_multiply #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEM_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    matrix_vector_multiply_checker #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEM_W)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .end_check      (end_check),
        .mismatch_count (mismatch_count),
        .rows_pending   (rows_pending),
        .sums_seen      (sums_seen),
        .errors_seen    (errors_seen),
        .matrices_seen  (matrices_seen)
    );

    // receiver back-pressure
    always @(negedge clk)
    begin
        case (ready_mode)
            READY_ALWAYS:  m_tready <= 1'b1;
            READY_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
            READY_PATTERN:
            begin
                ready_tick = (ready_tick + 1) % 7;
                m_tready <= (ready_tick < 4);
            end
            default:
            begin
                // alternating runs of ready and stall
                if (hold_left == 0)
                begin
                    hold_level = ~hold_level;
                    hold_left  = hold_level ? $urandom_range(1, 16) : $urandom_range(1, 12);
                end
                hold_left--;
                m_tready <= hold_level;
            end
        endcase
    end

    // watchdog: ends the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no traffic for %0d cycles, %0d results outstanding",
                     quiet_cycles, rows_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // register value for a dimension; sometimes one the block clamps
    function automatic logic [CFG_W-1:0] encode_dim(input int dim);
        if (dim == 1 && $urandom_range(0, 2) == 0)
            return '0;
        if (dim == MAX_DIM && $urandom_range(0, 1) == 0)
            return $urandom_range(0, 1) ? 7'd127 : CFG_W'($urandom_range(65, 127));
        return CFG_W'(dim);
    endfunction

    // one request; valid drops only between bursts
    task automatic send_req(input logic kind, input logic [ELEM_W-1:0] value);
        int gap;
        @(negedge clk);
        if (!sender_steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap        = $urandom_range(0, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
        // track the fill count so that random phases can complete a vector
        if (kind == REQ_VECTOR)
        begin
            if (vector_fill >= active_cols)
                vector_fill = 0;
            vector_fill++;
        end
    endtask

    // stop sending until every result is back and the pipeline is empty
    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (rows_pending != 0)
            @(posedge clk);
        repeat (PIPE_FLUSH) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_shape(input logic [CFG_W-1:0] rows_reg, input logic [CFG_W-1:0] cols_reg,
                             input logic tri_reg, input int used_cols);
        wait_for_results();
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, CFG_W'($urandom));
        write_reg(REG_ROW_COUNT, rows_reg);
        write_reg(REG_COLUMN_COUNT, cols_reg);
        write_reg(REG_TRIANGULAR_MODE, {{(CFG_W-1){1'b0}}, tri_reg});
        active_cols = used_cols;
        shapes_run++;
    endtask

    // one random shape: stray requests, vector, a few matrices, maybe cut short
    task automatic run_random_phase();
        int   rows;
        int   cols;
        int   reps;
        int   n;
        logic tri_mode;
        tri_mode = ($urandom_range(0, 9) < 3);
        if (tri_mode && $urandom_range(0, 4) != 0)
        begin
            rows = $urandom_range(1, 12);
            cols = rows;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    rows = MAX_DIM;
                    cols = $urandom_range(1, 4);
                end
                1:
                begin
                    rows = $urandom_range(1, 4);
                    cols = MAX_DIM;
                end
                2:
                begin
                    rows = 1;
                    cols = 1;
                end
                default:
                begin
                    rows = $urandom_range(1, 8);
                    cols = $urandom_range(1, 8);
                end
            endcase
        end
        sender_steady = ($urandom_range(0, 3) == 0);
        ready_mode    = ready_mode_t'($urandom_range(0, 3));
        set_shape(encode_dim(rows), encode_dim(cols), tri_mode, cols);

        // matrix requests before the vector is ready
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) send_req(REQ_MATRIX, pick_element());
        if (cols > 1 && $urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, cols - 1)) send_req(REQ_VECTOR, pick_element());
            send_req(REQ_MATRIX, pick_element());
        end

        // complete or reload the vector, or keep the one already loaded
        if (!(vector_fill == cols && $urandom_range(0, 2) == 0))
        begin
            n = (vector_fill < cols) ? cols - vector_fill : cols;
            repeat (n) send_req(REQ_VECTOR, pick_element());
        end

        reps = (rows * cols > 64) ? $urandom_range(1, 2) : $urandom_range(1, 3);
        for (int m = 0; m < reps; m++)
        begin
            n = rows * cols;
            // the last matrix may stop mid-row, carried into the next shape
            if (m == reps - 1 && $urandom_range(0, 5) == 0)
                n = $urandom_range(1, n);
            repeat (n) send_req(REQ_MATRIX, pick_element());
            if ($urandom_range(0, 4) == 0)
                wait_for_results();
        end

        // stray requests of either kind
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) send_req(1'($urandom_range(0, 1)), pick_element());
    endtask

    initial
    begin
        logic [ELEM_W-1:0] dense_vec [3];
        logic [ELEM_W-1:0] dense_mat [6];
        logic [ELEM_W-1:0] tri_mat   [9];
        int                random_start;
        dense_vec = '{16'h7FFF, 16'h8000, 16'h0001};
        dense_mat = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'hFFFF};
        tri_mat   = '{16'h1111, 16'h2222, 16'h3333, 16'h8000, 16'h7FFF, 16'h0F0F,
                      16'h7FFF, 16'h8000, 16'hFFFF};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // matrix request right after reset, vector still empty
        send_req(REQ_MATRIX, 16'h1234);

        // dense 2x3 with extreme elements
        set_shape(7'd2, 7'd3, 1'b0, 3);
        foreach (dense_vec[i])
            send_req(REQ_VECTOR, dense_vec[i]);
        foreach (dense_mat[i])
            send_req(REQ_MATRIX, dense_mat[i]);

        // a load on a full vector restarts it; the matrix request is then early
        send_req(REQ_VECTOR, 16'h4000);
        send_req(REQ_MATRIX, 16'h0100);
        send_req(REQ_VECTOR, 16'hC000);
        send_req(REQ_VECTOR, 16'h0800);

        // triangular with a non-square shape is refused
        set_shape(7'd2, 7'd3, 1'b1, 3);
        send_req(REQ_MATRIX, 16'h7FFF);

        // triangular 3x3 on the same vector: row 0 sums to zero
        set_shape(7'd3, 7'd3, 1'b1, 3);
        foreach (tri_mat[i])
            send_req(REQ_MATRIX, tri_mat[i]);

        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_REQUESTS)
            run_random_phase();

        wait_for_results();
        @(negedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Run covered %0d requests over %0d register settings.",
                 requests_sent, shapes_run);
        $display("Results: %0d row sums, %0d error results, %0d complete matrices.",
                 sums_seen, errors_seen, matrices_seen);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
